### hdl/swcf_pkg.sv
// Shared types and constants for the sliding-window circle fit core.
// No dependencies; every other file of the core imports this package.
package swcf_pkg;

  localparam int COORD_W  = 16;
  localparam int CFG_W    = 5;
  localparam int OUT_W    = 32;
  localparam int MW       = 64;
  localparam int WW       = 128;
  localparam int ROOT_W   = 48;
  localparam int RAD_IN_W = 2 * ROOT_W;
  localparam int AX_BITS  = 40;
  localparam int AX_W     = AX_BITS + 1;

  localparam logic             OP_ADD = 1'b0;
  localparam logic             OP_FIT = 1'b1;
  localparam logic [CFG_W-1:0] MIN_POINTS_RST = 5'd5;

  localparam logic [OUT_W-1:0] CENTER_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] CENTER_MIN = 32'h8000_0000;
  localparam logic [OUT_W-1:0] RADIUS_SAT = 32'hFFFF_FFFF;

  typedef logic signed [MW-1:0] op_t;
  typedef logic signed [WW-1:0] wide_t;

endpackage

### hdl/swcf_if.sv
// Valid/ready channel interfaces for point items and fit results.
// Depends on swcf_pkg for field widths.
interface swcf_in_if import swcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  modport source(output valid, op, point_x, point_y, input ready);
  modport sink(input valid, op, point_x, point_y, output ready);
endinterface

interface swcf_out_if import swcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    fit_valid;
  logic                    degenerate;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic [OUT_W-1:0]        radius;

  modport source(output valid, fit_valid, degenerate, center_x, center_y, radius,
                 input ready);
  modport sink(input valid, fit_valid, degenerate, center_x, center_y, radius,
               output ready);
endinterface

### hdl/swcf_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. Depends on swcf_pkg.
module swcf_mul import swcf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  op_t   a,
  input  op_t   b,
  output logic  done,
  output wide_t p
);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [WW-1:0] ma_r;
  logic [WW-1:0] acc_r;
  logic [MW-1:0] mb_r;
  wide_t         p_r;
  logic [MW-1:0] a_mag;
  logic [MW-1:0] b_mag;

  assign a_mag = a[MW-1] ? (~a + MW'(1)) : a;
  assign b_mag = b[MW-1] ? (~b + MW'(1)) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mb_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= {{(WW-MW){1'b0}}, a_mag};
      mb_r  <= b_mag;
      acc_r <= '0;
      neg_r <= a[MW-1] ^ b[MW-1];
    end else if (busy_r) begin
      if (mb_r == '0) begin
        p_r <= neg_r ? -$signed(acc_r) : $signed(acc_r);
      end else begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r <= {ma_r[WW-2:0], 1'b0};
        mb_r <= {1'b0, mb_r[MW-1:1]};
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

### hdl/swcf_div.sv
// Restoring unsigned divider, one quotient bit per cycle over the full width.
// Depends on swcf_pkg.
module swcf_div import swcf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] den,
  output logic          done,
  output logic [WW-1:0] q
);

  localparam int DC_W = $clog2(WW);

  logic            busy_r;
  logic            done_r;
  logic [DC_W-1:0] cnt_r;
  logic [WW-1:0]   n_r;
  logic [WW-1:0]   d_r;
  logic [WW-1:0]   rem_r;
  logic [WW-1:0]   q_r;
  logic [WW:0]     sh;
  logic [WW:0]     diff;
  logic            ge;

  assign sh   = {rem_r, n_r[WW-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge   = (sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DC_W'(WW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DC_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WW-1:0] : sh[WW-1:0];
      n_r   <= {n_r[WW-2:0], 1'b0};
      q_r   <= {q_r[WW-2:0], ge};
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

### hdl/swcf_sqrt.sv
// Integer square root, one root bit (two radicand bits) per cycle.
// Depends on swcf_pkg.
module swcf_sqrt import swcf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [RAD_IN_W-1:0] rad,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int SC_W = $clog2(ROOT_W);
  localparam int RW   = ROOT_W + 2;

  logic                busy_r;
  logic                done_r;
  logic [SC_W-1:0]     cnt_r;
  logic [RAD_IN_W-1:0] v_r;
  logic [RW-1:0]       rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [RW+1:0]       sh;
  logic [RW+1:0]       trial;
  logic [RW+1:0]       diff;
  logic                ge;

  assign sh    = {rem_r, v_r[RAD_IN_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = sh - trial;
  assign ge    = (sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SC_W'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SC_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[RW-1:0] : sh[RW-1:0];
      v_r    <= {v_r[RAD_IN_W-3:0], 2'b00};
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hdl/sliding_window_circle_fit_core.sv
// Sliding-window Kasa circle fit. An add transfer stores its point; a fit on too few
// points gives fit_valid low. A full fit walks the held points through the bit-serial
// multiplier for the sums, runs sixteen products and four divisions for the centre,
// walks the points again for the radius, then a fifth division and a root; a degenerate
// or saturated fit ends early. One item is in work at a time; a finished result waits
// in the output register. Synchronous active-low reset empties the window.
module sliding_window_circle_fit_core import swcf_pkg::*; #(
  parameter int WINDOW = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  swcf_in_if.sink          in_ch,
  swcf_out_if.source       out_ch
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ZW    = 2 * COORD_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LD, ST_MUL, ST_MWAIT, ST_DIV, ST_DWAIT, ST_SQRT, ST_SWAIT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    U_XX, U_YY, U_XY, U_XZ, U_YZ,
    U_UU1, U_UU2, U_VV1, U_VV2, U_UV1, U_UV2, U_UZ1, U_UZ2, U_VZ1, U_VZ2,
    U_D1, U_D2, U_NX1, U_NX2, U_NY1, U_NY2,
    U_DXX, U_DYY,
    U_QX, U_QY, U_QAX, U_QAY, U_QR
  } uop_t;

  state_t state_r;
  uop_t   uop_r;

  logic [COORD_W-1:0] win_x_mem [WINDOW];
  logic [COORD_W-1:0] win_y_mem [WINDOW];
  logic [COORD_W-1:0] rd_x_r;
  logic [COORD_W-1:0] rd_y_r;

  logic [CNT_W-1:0] held_r;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] idx_r;
  logic [CFG_W-1:0] minp_r;

  logic [COORD_W-1:0]   x_r;
  logic [COORD_W-1:0]   y_r;
  logic [2*COORD_W-1:0] xx_r;
  logic [ZW-1:0]        z_r;
  op_t sx_r, sy_r, sxx_r, syy_r, sxy_r, sxz_r, syz_r, sz_r;
  op_t t_r, cuu_r, cvv_r, cuv_r, cuz_r, cvz_r, dx_r, dy_r;
  wide_t w_r, den_r, numx_r, numy_r, tacc_r;
  logic signed [AX_W-1:0] ax_r;
  logic signed [AX_W-1:0] ay_r;

  logic             fv_r;
  logic             dg_r;
  logic [OUT_W-1:0] cx_r;
  logic [OUT_W-1:0] cy_r;
  logic [OUT_W-1:0] rad_r;

  logic             out_valid_r;
  logic             out_fv_r;
  logic             out_dg_r;
  logic [OUT_W-1:0] out_cx_r;
  logic [OUT_W-1:0] out_cy_r;
  logic [OUT_W-1:0] out_rad_r;

  logic          in_acc;
  logic          wr_en;
  logic          last_pt;
  logic          mul_done;
  logic          div_done;
  logic          sqrt_done;
  op_t           mul_a;
  op_t           mul_b;
  wide_t         mul_p;
  op_t           p64;
  wide_t         w_diff;
  logic [WW-1:0] div_num;
  logic [WW-1:0] div_den;
  logic [WW-1:0] div_q;
  logic [WW-1:0] nx_mag;
  logic [WW-1:0] ny_mag;
  logic [WW-1:0] m_sel;
  logic [ZW-1:0] z_sum;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   root_rnd;
  logic [AX_W-1:0]   q_ax;

  function automatic logic [OUT_W-1:0] sat_center(input logic neg, input logic [WW-1:0] q);
    logic [OUT_W-1:0] r;
    if (q[WW-1:OUT_W-1] != '0) begin
      r = neg ? CENTER_MIN : CENTER_MAX;
    end else begin
      r = neg ? (~q[OUT_W-1:0] + OUT_W'(1)) : q[OUT_W-1:0];
    end
    return r;
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign wr_en   = in_acc && (in_ch.op == OP_ADD);
  assign last_pt = ((CNT_W'(idx_r) + CNT_W'(1)) == held_r);
  assign p64     = mul_p[MW-1:0];
  assign w_diff  = w_r - mul_p;
  assign z_sum   = {1'b0, xx_r} + {1'b0, mul_p[2*COORD_W-1:0]};
  assign nx_mag  = numx_r[WW-1] ? (~numx_r + WW'(1)) : numx_r;
  assign ny_mag  = numy_r[WW-1] ? (~numy_r + WW'(1)) : numy_r;
  assign q_ax    = div_q[AX_W-1:0];
  assign root_rnd = {1'b0, root} + (ROOT_W+1)'(8);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_x_mem[slot_r] <= in_ch.point_x;
      win_y_mem[slot_r] <= in_ch.point_y;
    end
    rd_x_r <= win_x_mem[idx_r];
    rd_y_r <= win_y_mem[idx_r];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uop_r)
      U_XX:  begin mul_a = op_t'({{(MW-COORD_W){1'b0}}, x_r}); mul_b = mul_a; end
      U_YY:  begin mul_a = op_t'({{(MW-COORD_W){1'b0}}, y_r}); mul_b = mul_a; end
      U_XY:  begin
        mul_a = op_t'({{(MW-COORD_W){1'b0}}, x_r});
        mul_b = op_t'({{(MW-COORD_W){1'b0}}, y_r});
      end
      U_XZ:  begin
        mul_a = op_t'({{(MW-ZW){1'b0}}, z_r});
        mul_b = op_t'({{(MW-COORD_W){1'b0}}, x_r});
      end
      U_YZ:  begin
        mul_a = op_t'({{(MW-ZW){1'b0}}, z_r});
        mul_b = op_t'({{(MW-COORD_W){1'b0}}, y_r});
      end
      U_UU1: begin mul_a = sxx_r; mul_b = op_t'({{(MW-CNT_W){1'b0}}, held_r}); end
      U_UU2: begin mul_a = sx_r;  mul_b = sx_r; end
      U_VV1: begin mul_a = syy_r; mul_b = op_t'({{(MW-CNT_W){1'b0}}, held_r}); end
      U_VV2: begin mul_a = sy_r;  mul_b = sy_r; end
      U_UV1: begin mul_a = sxy_r; mul_b = op_t'({{(MW-CNT_W){1'b0}}, held_r}); end
      U_UV2: begin mul_a = sx_r;  mul_b = sy_r; end
      U_UZ1: begin mul_a = sxz_r; mul_b = op_t'({{(MW-CNT_W){1'b0}}, held_r}); end
      U_UZ2: begin mul_a = sz_r;  mul_b = sx_r; end
      U_VZ1: begin mul_a = syz_r; mul_b = op_t'({{(MW-CNT_W){1'b0}}, held_r}); end
      U_VZ2: begin mul_a = sz_r;  mul_b = sy_r; end
      U_D1:  begin mul_a = cuu_r; mul_b = cvv_r; end
      U_D2:  begin mul_a = cuv_r; mul_b = cuv_r; end
      U_NX1: begin mul_a = cuz_r; mul_b = cvv_r; end
      U_NX2: begin mul_a = cvz_r; mul_b = cuv_r; end
      U_NY1: begin mul_a = cvz_r; mul_b = cuu_r; end
      U_NY2: begin mul_a = cuz_r; mul_b = cuv_r; end
      U_DXX: begin mul_a = dx_r;  mul_b = dx_r; end
      U_DYY: begin mul_a = dy_r;  mul_b = dy_r; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (uop_r)
      U_QX:    m_sel = nx_mag;
      U_QY:    m_sel = ny_mag;
      U_QAX:   m_sel = {nx_mag[WW-5:0], 4'b0000};
      U_QAY:   m_sel = {ny_mag[WW-5:0], 4'b0000};
      default: m_sel = '0;
    endcase
    if (uop_r == U_QR) begin
      div_num = tacc_r;
      div_den = {{(WW-CNT_W){1'b0}}, held_r};
    end else begin
      div_num = {m_sel[WW-2:0], 1'b0} + den_r;
      div_den = {den_r[WW-2:0], 1'b0};
    end
  end

  swcf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  swcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  swcf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQRT),
    .rad   (div_q[RAD_IN_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      uop_r       <= U_XX;
      held_r      <= '0;
      slot_r      <= '0;
      idx_r       <= '0;
      minp_r      <= MIN_POINTS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        minp_r <= cfg_wdata;
      end
      if ((state_r == ST_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.op == OP_ADD) begin
              slot_r <= (slot_r == IDX_LAST) ? '0 : slot_r + IDX_W'(1);
              if (held_r != CNT_MAX) begin
                held_r <= held_r + CNT_W'(1);
              end
            end else begin
              cx_r  <= '0;
              cy_r  <= '0;
              rad_r <= '0;
              if (CMP_W'(held_r) < CMP_W'(minp_r)) begin
                fv_r    <= 1'b0;
                dg_r    <= 1'b0;
                state_r <= ST_DONE;
              end else if (held_r == '0) begin
                fv_r    <= 1'b1;
                dg_r    <= 1'b1;
                state_r <= ST_DONE;
              end else begin
                fv_r    <= 1'b1;
                dg_r    <= 1'b0;
                sx_r    <= '0;
                sy_r    <= '0;
                sxx_r   <= '0;
                syy_r   <= '0;
                sxy_r   <= '0;
                sxz_r   <= '0;
                syz_r   <= '0;
                sz_r    <= '0;
                idx_r   <= '0;
                uop_r   <= U_XX;
                state_r <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          state_r <= ST_LD;
        end
        ST_LD: begin
          if (uop_r == U_XX) begin
            x_r  <= rd_x_r;
            y_r  <= rd_y_r;
            sx_r <= sx_r + op_t'({{(MW-COORD_W){1'b0}}, rd_x_r});
            sy_r <= sy_r + op_t'({{(MW-COORD_W){1'b0}}, rd_y_r});
          end else begin
            dx_r <= op_t'({{(MW-COORD_W-4){1'b0}}, rd_x_r, 4'b0000})
                    - op_t'({{(MW-AX_W){ax_r[AX_W-1]}}, ax_r});
            dy_r <= op_t'({{(MW-COORD_W-4){1'b0}}, rd_y_r, 4'b0000})
                    - op_t'({{(MW-AX_W){ay_r[AX_W-1]}}, ay_r});
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            unique case (uop_r)
              U_XX:  begin
                sxx_r   <= sxx_r + p64;
                xx_r    <= mul_p[2*COORD_W-1:0];
                uop_r   <= U_YY;
                state_r <= ST_MUL;
              end
              U_YY:  begin
                syy_r   <= syy_r + p64;
                z_r     <= z_sum;
                sz_r    <= sz_r + op_t'({{(MW-ZW){1'b0}}, z_sum});
                uop_r   <= U_XY;
                state_r <= ST_MUL;
              end
              U_XY:  begin sxy_r <= sxy_r + p64; uop_r <= U_XZ; state_r <= ST_MUL; end
              U_XZ:  begin sxz_r <= sxz_r + p64; uop_r <= U_YZ; state_r <= ST_MUL; end
              U_YZ:  begin
                syz_r <= syz_r + p64;
                if (last_pt) begin
                  uop_r   <= U_UU1;
                  state_r <= ST_MUL;
                end else begin
                  idx_r   <= idx_r + IDX_W'(1);
                  uop_r   <= U_XX;
                  state_r <= ST_RD;
                end
              end
              U_UU1: begin t_r <= p64; uop_r <= U_UU2; state_r <= ST_MUL; end
              U_UU2: begin cuu_r <= t_r - p64; uop_r <= U_VV1; state_r <= ST_MUL; end
              U_VV1: begin t_r <= p64; uop_r <= U_VV2; state_r <= ST_MUL; end
              U_VV2: begin cvv_r <= t_r - p64; uop_r <= U_UV1; state_r <= ST_MUL; end
              U_UV1: begin t_r <= p64; uop_r <= U_UV2; state_r <= ST_MUL; end
              U_UV2: begin cuv_r <= t_r - p64; uop_r <= U_UZ1; state_r <= ST_MUL; end
              U_UZ1: begin t_r <= p64; uop_r <= U_UZ2; state_r <= ST_MUL; end
              U_UZ2: begin cuz_r <= t_r - p64; uop_r <= U_VZ1; state_r <= ST_MUL; end
              U_VZ1: begin t_r <= p64; uop_r <= U_VZ2; state_r <= ST_MUL; end
              U_VZ2: begin cvz_r <= t_r - p64; uop_r <= U_D1; state_r <= ST_MUL; end
              U_D1:  begin w_r <= mul_p; uop_r <= U_D2; state_r <= ST_MUL; end
              U_D2:  begin
                if (w_diff[WW-1] || (w_diff == '0)) begin
                  dg_r    <= 1'b1;
                  state_r <= ST_DONE;
                end else begin
                  den_r   <= {w_diff[WW-2:0], 1'b0};
                  uop_r   <= U_NX1;
                  state_r <= ST_MUL;
                end
              end
              U_NX1: begin w_r <= mul_p; uop_r <= U_NX2; state_r <= ST_MUL; end
              U_NX2: begin numx_r <= w_diff; uop_r <= U_NY1; state_r <= ST_MUL; end
              U_NY1: begin w_r <= mul_p; uop_r <= U_NY2; state_r <= ST_MUL; end
              U_NY2: begin numy_r <= w_diff; uop_r <= U_QX; state_r <= ST_DIV; end
              U_DXX: begin
                tacc_r  <= tacc_r + mul_p;
                uop_r   <= U_DYY;
                state_r <= ST_MUL;
              end
              U_DYY: begin
                tacc_r <= tacc_r + mul_p;
                if (last_pt) begin
                  uop_r   <= U_QR;
                  state_r <= ST_DIV;
                end else begin
                  idx_r   <= idx_r + IDX_W'(1);
                  uop_r   <= U_DXX;
                  state_r <= ST_RD;
                end
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          state_r <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            unique case (uop_r)
              U_QX: begin
                cx_r    <= sat_center(numx_r[WW-1], div_q);
                uop_r   <= U_QY;
                state_r <= ST_DIV;
              end
              U_QY: begin
                cy_r    <= sat_center(numy_r[WW-1], div_q);
                uop_r   <= U_QAX;
                state_r <= ST_DIV;
              end
              U_QAX: begin
                if (div_q[WW-1:AX_BITS] != '0) begin
                  rad_r   <= RADIUS_SAT;
                  state_r <= ST_DONE;
                end else begin
                  ax_r    <= numx_r[WW-1] ? -$signed(q_ax) : $signed(q_ax);
                  uop_r   <= U_QAY;
                  state_r <= ST_DIV;
                end
              end
              U_QAY: begin
                if (div_q[WW-1:AX_BITS] != '0) begin
                  rad_r   <= RADIUS_SAT;
                  state_r <= ST_DONE;
                end else begin
                  ay_r    <= numy_r[WW-1] ? -$signed(q_ax) : $signed(q_ax);
                  idx_r   <= '0;
                  tacc_r  <= '0;
                  uop_r   <= U_DXX;
                  state_r <= ST_RD;
                end
              end
              U_QR: begin
                state_r <= ST_SQRT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SQRT: begin
          state_r <= ST_SWAIT;
        end
        ST_SWAIT: begin
          if (sqrt_done) begin
            if (root_rnd[ROOT_W:OUT_W+4] != '0) begin
              rad_r <= RADIUS_SAT;
            end else begin
              rad_r <= root_rnd[OUT_W+3:4];
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_fv_r    <= fv_r;
            out_dg_r    <= dg_r;
            out_cx_r    <= cx_r;
            out_cy_r    <= cy_r;
            out_rad_r   <= rad_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.fit_valid  = out_fv_r;
  assign out_ch.degenerate = out_dg_r;
  assign out_ch.center_x   = $signed(out_cx_r);
  assign out_ch.center_y   = $signed(out_cy_r);
  assign out_ch.radius     = out_rad_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_MAX)
    else $error("held point count exceeds the window depth");

  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MWAIT))
    else $error("multiplier finished while the sequencer was not waiting on it");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DWAIT))
    else $error("divider finished while the sequencer was not waiting on it");

  a_degen_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate) |-> out_ch.fit_valid)
    else $error("degenerate result without a valid fit");

endmodule
